// ===== rtl/core/gbs_pkg.sv =====
// shared constants, types and state codes for the greedy box suppression block
package gbs_pkg;

    localparam int MAX_KEPT  = 256;
    localparam int MAX_BOXES = 4096;

    localparam int COORD_W   = 16;
    localparam int AREA_W    = 32;
    localparam int THR_W     = 16;
    localparam int NUM_W     = 12;
    localparam int IDX_W     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W     = $clog2(MAX_KEPT + 1);
    localparam int BOX_CNT_W = $clog2(MAX_BOXES);

    localparam int EDGE_W    = COORD_W + 1;
    localparam int SUM_W     = AREA_W + 1;
    localparam int INTER_W   = 2 * EDGE_W;
    localparam int PROD_W    = THR_W + INTER_W;

    localparam int IOU_LAT   = 5;
    localparam int DRAIN_W   = $clog2(IOU_LAT);

    localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic [AREA_W-1:0]  area;
    } t_entry;

    typedef struct packed {
        logic valid;
        logic suppress;
    } t_iou_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AREA,
        S_SWEEP,
        S_DRAIN,
        S_FINISH
    } t_state;

endpackage

// ===== rtl/core/gbs_cell.sv =====
// one cell of the kept-box ring, passes its entry to the next cell on a shift
module gbs_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  gbs_pkg::t_entry i_prev,
    output gbs_pkg::t_entry o_entry
);
    import gbs_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_prev;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/core/gbs_iou.sv =====
// pipelined overlap test of the candidate box against one kept box
module gbs_iou (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  gbs_pkg::t_entry           i_cand,
    input  gbs_pkg::t_entry           i_kept,
    input  logic [gbs_pkg::THR_W-1:0] i_threshold,
    output gbs_pkg::t_iou_result      o_result
);
    import gbs_pkg::*;

    logic [EDGE_W-1:0]  x0, y0, ar, br, ab, bb, x1, y1;
    logic [EDGE_W-1:0]  n_dx, n_dy;

    logic               r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [EDGE_W-1:0]  r_dx, r_dy;
    logic [SUM_W-1:0]   r_sum1, r_sum2;
    logic [INTER_W-1:0] r_inter2, r_inter3;
    logic [INTER_W-1:0] r_uni;
    logic [PROD_W-1:0]  r_lhs, r_prod;
    logic               r_supp;

    always_comb begin
        x0 = (i_cand.left > i_kept.left) ? EDGE_W'(i_cand.left) : EDGE_W'(i_kept.left);
        y0 = (i_cand.top > i_kept.top) ? EDGE_W'(i_cand.top) : EDGE_W'(i_kept.top);
        ar = EDGE_W'(i_cand.left) + EDGE_W'(i_cand.width);
        br = EDGE_W'(i_kept.left) + EDGE_W'(i_kept.width);
        ab = EDGE_W'(i_cand.top) + EDGE_W'(i_cand.height);
        bb = EDGE_W'(i_kept.top) + EDGE_W'(i_kept.height);
        x1 = (ar < br) ? ar : br;
        y1 = (ab < bb) ? ab : bb;
        n_dx = (x1 > x0) ? x1 - x0 : '0;
        n_dy = (y1 > y0) ? y1 - y0 : '0;
        if (x1 <= x0 || y1 <= y0) begin
            n_dx = '0;
            n_dy = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_sum1   <= SUM_W'(i_cand.area) + SUM_W'(i_kept.area);
        r_inter2 <= INTER_W'(r_dx) * INTER_W'(r_dy);
        r_sum2   <= r_sum1;
        r_uni    <= INTER_W'(r_sum2) - r_inter2;
        r_inter3 <= r_inter2;
        r_prod   <= PROD_W'(i_threshold) * PROD_W'(r_uni);
        r_lhs    <= {r_inter3, {THR_W{1'b0}}};
        r_supp   <= r_lhs > r_prod;
    end

    assign o_result.valid    = r_v5;
    assign o_result.suppress = r_supp;

endmodule

// ===== rtl/core/greedy_box_suppression.sv =====
// greedy box suppression top level: kept-box ring, shared overlap test, control
//
// Boxes arrive sorted by descending score, one request at a time. Every box passes
// these steps from one accepted request to the next: its area, one full rotation
// of the kept-box ring past the single overlap unit (one kept entry per cycle), the
// drain of the five-stage overlap pipeline, and, once the output register is free,
// posting the result and appending a survivor at the head of the ring if the store
// has room. The result waits in an output register, so a new request is taken
// while it is still unclaimed. A set ends with the box marked set_end; the ring
// needs no clearing, only its fill count returns to zero.
module greedy_box_suppression (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [gbs_pkg::THR_W-1:0]   i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [gbs_pkg::COORD_W-1:0] i_box_left,
    input  logic [gbs_pkg::COORD_W-1:0] i_box_top,
    input  logic [gbs_pkg::COORD_W-1:0] i_box_width,
    input  logic [gbs_pkg::COORD_W-1:0] i_box_height,
    input  logic                        i_set_end,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [gbs_pkg::NUM_W-1:0]   o_box_number,
    output logic                        o_kept,
    output logic                        o_store_full,
    output logic                        o_set_done
);
    import gbs_pkg::*;

    t_state             r_state, n_state;
    logic [THR_W-1:0]   r_thr;
    t_entry             r_cand;
    logic               r_end;
    logic [IDX_W-1:0]   r_step;
    logic [DRAIN_W-1:0] r_drain;
    logic               r_suppress;
    logic [CNT_W-1:0]   r_count;
    logic [BOX_CNT_W-1:0] r_box_cnt;

    logic               r_out_valid;
    logic [NUM_W-1:0]   r_out_num;
    logic               r_out_kept, r_out_full, r_out_done;

    t_entry             cell_q [MAX_KEPT];
    t_entry             ring_in;
    logic               shift_en, iou_issue, out_load, keep, full, accept;
    logic [IDX_W-1:0]   head_idx;
    t_iou_result        iou_res;

    assign accept   = i_in_valid && o_in_ready;
    assign head_idx = IDX_W'(MAX_KEPT - 1) - r_step;
    assign keep     = !r_suppress;
    assign full     = keep && (r_count == CNT_W'(MAX_KEPT));
    assign ring_in  = (r_state == S_SWEEP) ? cell_q[MAX_KEPT-1] : r_cand;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEPT; gi++) begin : g_ring
            if (gi == 0) begin : g_head
                gbs_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (shift_en),
                    .i_prev  (ring_in),
                    .o_entry (cell_q[gi])
                );
            end else begin : g_body
                gbs_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (shift_en),
                    .i_prev  (cell_q[gi-1]),
                    .o_entry (cell_q[gi])
                );
            end
        end
    endgenerate

    gbs_iou u_iou (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (iou_issue),
        .i_cand      (r_cand),
        .i_kept      (cell_q[MAX_KEPT-1]),
        .i_threshold (r_thr),
        .o_result    (iou_res)
    );

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        iou_issue  = 1'b0;
        shift_en   = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_AREA;
                end
            end
            S_AREA: begin
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                shift_en  = 1'b1;
                iou_issue = CNT_W'(head_idx) < r_count;
                if (r_step == IDX_W'(MAX_KEPT - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_drain == DRAIN_W'(IOU_LAT - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    shift_en = keep && !full;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= THR_RESET;
            r_step      <= '0;
            r_drain     <= '0;
            r_suppress  <= 1'b0;
            r_count     <= '0;
            r_box_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            if (r_state == S_SWEEP) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
            if (r_state == S_DRAIN) begin
                r_drain <= r_drain + 1'b1;
            end else begin
                r_drain <= '0;
            end
            if (accept) begin
                r_suppress <= 1'b0;
            end else if (iou_res.valid && iou_res.suppress) begin
                r_suppress <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                if (r_end) begin
                    r_count   <= '0;
                    r_box_cnt <= '0;
                end else begin
                    if (keep && !full) begin
                        r_count <= r_count + 1'b1;
                    end
                    if (r_box_cnt == BOX_CNT_W'(MAX_BOXES - 1)) begin
                        r_box_cnt <= '0;
                    end else begin
                        r_box_cnt <= r_box_cnt + 1'b1;
                    end
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cand.left   <= i_box_left;
            r_cand.top    <= i_box_top;
            r_cand.width  <= i_box_width;
            r_cand.height <= i_box_height;
            r_end         <= i_set_end;
        end
        if (r_state == S_AREA) begin
            r_cand.area <= AREA_W'(r_cand.width) * AREA_W'(r_cand.height);
        end
        if (out_load) begin
            r_out_num  <= NUM_W'(r_box_cnt);
            r_out_kept <= keep;
            r_out_full <= full;
            r_out_done <= r_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_box_number = r_out_num;
    assign o_kept       = r_out_kept;
    assign o_store_full = r_out_full;
    assign o_set_done   = r_out_done;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KEPT))
        else $error("kept count beyond store depth");

    a_iou_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iou_res.valid |-> (r_state == S_SWEEP || r_state == S_DRAIN))
        else $error("overlap result outside sweep and drain");

    a_full_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_store_full |-> o_kept)
        else $error("store full flagged on a suppressed box");

    a_accept_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_AREA)
        else $error("accepted request did not start area cycle");

    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && shift_en) |-> r_count < CNT_W'(MAX_KEPT))
        else $error("append into a full store");

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the greedy box suppression block
`timescale 1ns / 100ps

module testbench;

    import gbs_pkg::*;

    localparam int BOX_CYCLES  = MAX_KEPT + IOU_LAT + 3;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RANDOM_BOXES = 120;

    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic             kept;
        logic             full;
        logic             done;
    } t_verdict;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_wr_en   = 1'b0;
    logic [THR_W-1:0]    i_cfg_wr_data = '0;
    logic                i_in_valid    = 1'b0;
    logic [COORD_W-1:0]  i_box_left    = '0;
    logic [COORD_W-1:0]  i_box_top     = '0;
    logic [COORD_W-1:0]  i_box_width   = '0;
    logic [COORD_W-1:0]  i_box_height  = '0;
    logic                i_set_end     = 1'b0;
    logic                i_out_ready   = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [NUM_W-1:0]    o_box_number;
    logic                o_kept;
    logic                o_store_full;
    logic                o_set_done;

    // predictor state
    t_entry              held_boxes [MAX_KEPT];
    int unsigned         held_count;
    int unsigned         box_index;
    logic [THR_W-1:0]    iou_threshold_now;

    t_verdict            pending_verdicts [$];
    t_verdict            newest_verdict;
    t_verdict            oldest_verdict;

    int                  mismatches;
    int                  cycles;
    int                  boxes_sent;
    int                  random_sent;
    int                  kept_seen;
    int                  suppressed_seen;
    int                  overflow_seen;
    int                  sets_seen;
    int                  thresholds_written;
    int                  stall_left;
    bit                  calm;

    greedy_box_suppression dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_box_left    (i_box_left),
        .i_box_top     (i_box_top),
        .i_box_width   (i_box_width),
        .i_box_height  (i_box_height),
        .i_set_end     (i_set_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_box_number  (o_box_number),
        .o_kept        (o_kept),
        .o_store_full  (o_store_full),
        .o_set_done    (o_set_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_verdicts.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint unsigned overlap_of(input t_entry a,
                                                   input logic [COORD_W-1:0] l,
                                                   input logic [COORD_W-1:0] t,
                                                   input logic [COORD_W-1:0] w,
                                                   input logic [COORD_W-1:0] h);
        int unsigned     x0, y0, x1, y1, ar, ab, br, bb;
        longint unsigned dx, dy;
        x0 = (l > a.left) ? l : a.left;
        y0 = (t > a.top) ? t : a.top;
        ar = l + w;
        br = a.left + a.width;
        ab = t + h;
        bb = a.top + a.height;
        x1 = (ar < br) ? ar : br;
        y1 = (ab < bb) ? ab : bb;
        if (x1 <= x0 || y1 <= y0)
            return 0;
        dx = x1 - x0;
        dy = y1 - y0;
        return dx * dy;
    endfunction

    // greedy suppression of one box against the held set, updates the set
    function automatic t_verdict judge_box(input logic [COORD_W-1:0] l,
                                           input logic [COORD_W-1:0] t,
                                           input logic [COORD_W-1:0] w,
                                           input logic [COORD_W-1:0] h,
                                           input logic e);
        longint unsigned area, inter, union_sum, thr;
        logic            keep;
        logic            full;
        t_verdict        v;
        area = w;
        area = area * h;
        thr  = iou_threshold_now;
        keep = 1'b1;
        full = 1'b0;
        for (int j = 0; j < held_count; j++) begin
            inter     = overlap_of(held_boxes[j], l, t, w, h);
            union_sum = area + held_boxes[j].area - inter;
            if ((inter << 16) > thr * union_sum)
                keep = 1'b0;
        end
        if (keep) begin
            if (held_count < MAX_KEPT) begin
                held_boxes[held_count] = '{left: l, top: t, width: w, height: h,
                                           area: area[AREA_W-1:0]};
                held_count++;
            end else begin
                full = 1'b1;
            end
        end
        v.number = box_index[NUM_W-1:0];
        v.kept   = keep;
        v.full   = full;
        v.done   = e;
        if (e) begin
            held_count = 0;
            box_index  = 0;
        end else begin
            box_index = (box_index + 1) % MAX_BOXES;
        end
        return v;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // request monitor and result checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                newest_verdict = judge_box(i_box_left, i_box_top, i_box_width,
                                           i_box_height, i_set_end);
                pending_verdicts.insert(pending_verdicts.size(), newest_verdict);
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_verdicts.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result for box %0d", o_box_number));
                end else begin
                    oldest_verdict = pending_verdicts.pop_front();
                    if (o_box_number !== oldest_verdict.number)
                        flag_mismatch($sformatf("box_number %0d, want %0d",
                                                o_box_number, oldest_verdict.number));
                    if (o_kept !== oldest_verdict.kept)
                        flag_mismatch($sformatf("box %0d kept %b, want %b",
                                                oldest_verdict.number, o_kept,
                                                oldest_verdict.kept));
                    if (o_store_full !== oldest_verdict.full)
                        flag_mismatch($sformatf("box %0d store_full %b, want %b",
                                                oldest_verdict.number, o_store_full,
                                                oldest_verdict.full));
                    if (o_set_done !== oldest_verdict.done)
                        flag_mismatch($sformatf("box %0d set_done %b, want %b",
                                                oldest_verdict.number, o_set_done,
                                                oldest_verdict.done));
                    if (!oldest_verdict.kept)
                        suppressed_seen++;
                    else if (oldest_verdict.full)
                        overflow_seen++;
                    else
                        kept_seen++;
                    if (oldest_verdict.done)
                        sets_seen++;
                end
            end
        end
    end

    // result side backpressure, with occasional long holds
    always @(negedge i_clk) begin
        if (calm) begin
            i_out_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left  = stall_left - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(1999) == 0) begin
            stall_left  = $urandom_range(300, 700);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 36);
        end
    end

    function automatic logic [COORD_W-1:0] clamp16(input int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return '1;
        return v[COORD_W-1:0];
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_box(input logic [COORD_W-1:0] l, input logic [COORD_W-1:0] t,
                            input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                            input logic e);
        int gap;
        i_box_left   = l;
        i_box_top    = t;
        i_box_width  = w;
        i_box_height = h;
        i_set_end    = e;
        i_in_valid   = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        boxes_sent++;
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 36) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 3);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        wait_drained();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en       = 1'b0;
        iou_threshold_now = value;
        thresholds_written++;
    endtask

    // runs on the threshold left by reset
    task automatic check_reset_threshold_overlap();
        send_box(16'd1600, 16'd1600, 16'd800, 16'd800, 1'b0);
        send_box(16'd1600, 16'd1600, 16'd800, 16'd800, 1'b0);
        send_box(16'd1760, 16'd1600, 16'd800, 16'd800, 1'b0);
        send_box(16'd2000, 16'd1600, 16'd800, 16'd800, 1'b0);
        // zero-area pair: zero union keeps both
        send_box(16'd0, 16'd0, 16'd0, 16'd120, 1'b0);
        send_box(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_box(16'd1700, 16'd1650, 16'd700, 16'd750, 1'b1);
    endtask

    // 17-bit right and bottom edges
    task automatic check_field_extremes();
        send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_box(16'hFFFE, 16'hFFFE, 16'hFFFF, 16'hFFFF, 1'b0);
        send_box(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
        send_box(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b1);
    endtask

    task automatic check_threshold_extremes();
        write_threshold('0);
        send_box(16'd800, 16'd800, 16'd320, 16'd320, 1'b0);
        send_box(16'd1120, 16'd800, 16'd320, 16'd320, 1'b0);
        send_box(16'd1119, 16'd800, 16'd320, 16'd320, 1'b0);
        send_box(16'd5000, 16'd5000, 16'd0, 16'd0, 1'b0);
        send_box(16'd5000, 16'd5000, 16'd0, 16'd0, 1'b1);
        write_threshold('1);
        send_box(16'd800, 16'd800, 16'd320, 16'd320, 1'b0);
        send_box(16'd800, 16'd800, 16'd320, 16'd320, 1'b0);
        send_box(16'd640, 16'd640, 16'd640, 16'd640, 1'b1);
    endtask

    // one box per column so nothing overlaps until the store is full
    task automatic check_store_overflow();
        logic [COORD_W-1:0] l, t, w, h;
        logic [COORD_W-1:0] l0, t0, w0, h0;
        write_threshold(THR_RESET);
        for (int k = 0; k < MAX_KEPT; k++) begin
            l = COORD_W'(k * 256 + $urandom_range(0, 100));
            t = COORD_W'($urandom_range(0, 60000));
            w = COORD_W'($urandom_range(16, 64));
            h = COORD_W'($urandom_range(1, 1000));
            if (k == 0) begin
                l0 = l;
                t0 = t;
                w0 = w;
                h0 = h;
            end
            send_box(l, t, w, h, 1'b0);
        end
        send_box(16'd200, 16'd500, 16'd40, 16'd40, 1'b0);
        send_box(l0, t0, w0, h0, 1'b0);
        // the overflow box was never stored, so its twin survives
        send_box(16'd200, 16'd500, 16'd40, 16'd40, 1'b0);
        send_box(16'd30000, 16'd30000, 16'd0, 16'd0, 1'b1);
        send_box(l0, t0, w0, h0, 1'b1);
    endtask

    task automatic check_random_sets();
        int set_len, cx, cy, bw, bh;
        logic [COORD_W-1:0] l, t, w, h;
        while (random_sent < RANDOM_BOXES) begin
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(5))
                    0:       write_threshold('0);
                    1:       write_threshold('1);
                    2:       write_threshold(THR_RESET);
                    default: write_threshold(THR_W'($urandom_range(0, 65535)));
                endcase
            end
            set_len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int k = 0; k < set_len; k++) begin
                calm = (random_sent >= 30 && random_sent < 100);
                if (k == 0 || $urandom_range(4) == 0) begin
                    cx = $urandom_range(0, 60000);
                    cy = $urandom_range(0, 60000);
                    bw = $urandom_range(16, 4000);
                    bh = $urandom_range(16, 4000);
                end
                if ($urandom_range(99) < 15) begin
                    l = COORD_W'($urandom_range(0, 65535));
                    t = COORD_W'($urandom_range(0, 65535));
                    w = ($urandom_range(3) == 0) ? '0 : COORD_W'($urandom_range(0, 65535));
                    h = ($urandom_range(3) == 0) ? '0 : COORD_W'($urandom_range(0, 65535));
                end else begin
                    l = clamp16(cx + int'($urandom_range(0, bw / 2)) - bw / 4);
                    t = clamp16(cy + int'($urandom_range(0, bh / 2)) - bh / 4);
                    w = clamp16(bw * int'($urandom_range(75, 125)) / 100);
                    h = clamp16(bh * int'($urandom_range(75, 125)) / 100);
                    if ($urandom_range(19) == 0)
                        w = '0;
                end
                send_box(l, t, w, h, k == set_len - 1);
                random_sent++;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        iou_threshold_now = THR_RESET;
        held_count        = 0;
        box_index         = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        check_reset_threshold_overlap();
        check_field_extremes();
        check_threshold_extremes();
        check_store_overflow();
        check_random_sets();

        wait_drained();
        repeat (BOX_CYCLES + 8) @(posedge i_clk);
        if (pending_verdicts.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));

        $display("%0d boxes in %0d sets: %0d kept, %0d suppressed, %0d kept with store full",
                 boxes_sent, sets_seen, kept_seen, suppressed_seen, overflow_seen);
        $display("%0d threshold writes, %0d mismatches", thresholds_written, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
